@@ sv/ple_pkg.sv @@
`default_nettype none

package ple_pkg;

  // List geometry
  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;

  // Fixed field widths
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;

  // Derived widths: count holds 0..DEPTH, index addresses 0..DEPTH-1
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Common width for position / count / index compares, with one bit of headroom
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    opcode_e                  opcode;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value_in;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [VAL_W-1:0]  value_out;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length_out;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_item;  // capture the accepted item, restart the scan
    logic scan_step;  // advance the locate scan by one entry
    logic emit;       // commit the operation and load the result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_locate;
    logic scan_hit;   // entry under the scan pointer matches the search word
    logic scan_done;  // scan pointer is at the last valid entry (or list empty)
  } stat_t;

endpackage

`default_nettype wire

@@ sv/ple_datapath.sv @@
`default_nettype none

module ple_datapath import ple_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output out_item_t out_item_o
);

  logic [WORD_WIDTH-1:0] cell_q [DEPTH];
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      scan_q;
  opcode_e               op_q;
  logic [POS_W-1:0]      pos_q;
  logic [WORD_WIDTH-1:0] word_q;
  out_item_t             out_q, out_d;

  logic [CMP_W-1:0]      pos_x, cnt_x, scan_x, pos_m1;
  logic [IDX_W-1:0]      rd_idx;
  logic [WORD_WIDTH-1:0] rd_word;
  logic                  ins_pos_ok, rd_pos_ok, full, empty, hit, done;
  logic                  do_ins, do_del;
  status_e               status;
  logic [VAL_W-1:0]      val;
  logic [POS_W-1:0]      fpos;

  // Position and length checks
  assign pos_x      = CMP_W'(pos_q);
  assign cnt_x      = CMP_W'(count_q);
  assign scan_x     = CMP_W'(scan_q);
  assign pos_m1     = pos_x - CMP_W'(1);
  assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign rd_pos_ok  = (pos_x != '0) && (pos_x <= cnt_x);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  // Single read port: scan pointer for locate, position otherwise
  assign rd_idx  = (op_q == OP_LOCATE) ? scan_q : pos_m1[IDX_W-1:0];
  assign rd_word = cell_q[rd_idx];
  assign hit     = (scan_x < cnt_x) && (rd_word == word_q);
  assign done    = (scan_x + CMP_W'(1) >= cnt_x);

  assign stat_o.is_locate = (op_q == OP_LOCATE);
  assign stat_o.scan_hit  = hit;
  assign stat_o.scan_done = done;

  // Result and update decision
  always_comb begin
    status = ST_OK;
    val    = '0;
    fpos   = '0;
    do_ins = 1'b0;
    do_del = 1'b0;
    case (op_q)
      OP_INSERT: begin
        if (!ins_pos_ok) begin
          status = ST_BAD_POS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_DELETE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!rd_pos_ok) begin
          status = ST_BAD_POS;
        end else begin
          val    = VAL_W'(rd_word);
          do_del = 1'b1;
        end
      end
      OP_GET: begin
        if (!rd_pos_ok) begin
          status = ST_BAD_POS;
        end else begin
          val = VAL_W'(rd_word);
        end
      end
      OP_LOCATE: begin
        if (hit) begin
          val  = VAL_W'(rd_word);
          fpos = POS_W'(scan_x + CMP_W'(1));
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: begin
        status = ST_BAD_POS;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_del) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign out_d.status          = status;
  assign out_d.value_out       = val;
  assign out_d.found_position  = fpos;
  assign out_d.list_length_out = POS_W'(count_d);

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= in_item_i.opcode;
      pos_q  <= in_item_i.position;
      word_q <= in_item_i.value_in[WORD_WIDTH-1:0];
    end
  end

  // Scan pointer and length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.load_item) begin
        scan_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (cmd_i.emit) begin
        count_q <= count_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

  // Cell array: every cell at or above the target position shifts in parallel on a committed insert or delete
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] up_src, dn_src;
    logic                  at_or_above;

    assign at_or_above = (CMP_W'(i) >= pos_m1);

    if (i == 0) begin : g_first
      assign up_src = word_q;
    end else begin : g_mid
      assign up_src = (CMP_W'(i) == pos_m1) ? word_q : cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign dn_src = cell_q[i];
    end else begin : g_inner
      assign dn_src = cell_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.emit && do_ins && at_or_above) begin
        cell_q[i] <= up_src;
      end else if (cmd_i.emit && do_del && at_or_above) begin
        cell_q[i] <= dn_src;
      end
    end
  end

  // Length never runs past the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list length exceeds capacity");

  // Length only moves when an operation commits
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.emit |=> $stable(count_q))
    else $error("list length changed without a commit");

endmodule

`default_nettype wire

@@ sv/ple_controller.sv @@
`default_nettype none

module ple_controller import ple_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, finish;

  // Result slot can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // Operation is ready to finish: everything but an unfinished locate scan
  assign finish   = !stat_i.is_locate || stat_i.scan_hit || stat_i.scan_done;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!finish) begin
          cmd_o.scan_step = 1'b1;
        end else if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set by a new result, held until its transfer
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten before transfer");

  // An accepted item always goes to execution
  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> (state_q == S_EXEC))
    else $error("accepted item not executed");

  // Scan and commit are exclusive
  a_step_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.scan_step && cmd_o.emit))
    else $error("scan step and commit in the same cycle");

endmodule

`default_nettype wire

@@ sv/positional_list_engine.sv @@
// Ordered list of up to DEPTH words with insert, delete, get and locate by
// value, one result per item. After an item transfer the block stalls its
// input until the result is loaded into the output register. Insert,
// delete and get need no scan; locate compares one stored entry per cycle
// through the list's single read port, from the first entry until a match
// or the last valid entry. A waiting result does not block the next
// item's transfer, only the loading of the next result. After reset the
// list is empty.
`default_nettype none

module positional_list_engine import ple_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t  cmd;
  stat_t stat;

  ple_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ple_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
